FILE: rtl/ghrs_pkg.sv
package ghrs_pkg;

    localparam int BLOCK_CELLS = 16;
    localparam int NX          = 3 * BLOCK_CELLS;
    localparam int ROWLEN      = NX + 1;
    localparam int NPTS        = ROWLEN * ROWLEN;
    localparam int LO1         = BLOCK_CELLS;
    localparam int LO2         = 2 * BLOCK_CELLS;
    localparam int CW          = $clog2(ROWLEN);
    localparam int AW          = $clog2(NPTS);
    localparam logic [19:0] SWEEP_MAX = 20'hFFFFF;

    typedef enum logic [1:0] {
        K_INIT  = 2'd0,
        K_SWEEP = 2'd1,
        K_READ  = 2'd2,
        K_NOP   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        R_BOTTOM = 3'd0,
        R_LEFT   = 3'd1,
        R_RIGHT  = 3'd2,
        R_DROP   = 3'd3,
        R_SOURCE = 3'd4,
        R_TOL    = 3'd5
    } t_reg;

    function automatic logic [31:0] sat32(input logic signed [35:0] v);
        logic [31:0] r;
        if (v > 36'sd2147483647) begin
            r = 32'h7FFF_FFFF;
        end else if (v < -36'sd2147483648) begin
            r = 32'h8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/ghrs_if.sv
interface ghrs_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [5:0] column;
    logic [5:0] row;
    modport source (output valid, kind, column, row, input ready);
    modport sink (input valid, kind, column, row, output ready);
endinterface

interface ghrs_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic        converged;
    logic [19:0] sweep_count;
    modport source (output valid, value, converged, sweep_count, input ready);
    modport sink (input valid, value, converged, sweep_count, output ready);
endinterface

interface ghrs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/grid_heat_relaxation_solver.sv
// Temperature grid solver on a 49 x 49 point grid with a hole in the middle block.
// One item at a time. Initialize writes every point once. A sweep visits each
// inner point outside the hole with a scan cycle, five memory reads through the
// single read port, each an address cycle and a wait cycle, a compute cycle and
// a write cycle; points inside the hole off its rim are only scanned, while top
// edge points and hole rim points read one neighbour (two at the hole corners).
// A read presents its address in idle; the memory data is registered and then
// copied into the output register. Results leave through an output register; the next
// item is accepted once the result beat has been taken.
module grid_heat_relaxation_solver
    import ghrs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    ghrs_in_if.sink    in_ch,
    ghrs_out_if.source out_ch,
    ghrs_cfg_if.sink   cfg_ch
);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_INIT  = 9'b000000010,
        S_SCAN  = 9'b000000100,
        S_RD    = 9'b000001000,
        S_WAIT  = 9'b000010000,
        S_CALC  = 9'b000100000,
        S_WR    = 9'b001000000,
        S_READ  = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    // phases of a sweep
    typedef enum logic [1:0] {
        P_INNER = 2'd0,
        P_TOP   = 2'd1,
        P_HOLE  = 2'd2
    } t_phase;

    t_state r_state, n_state;
    t_phase r_phase;

    logic [31:0] r_bottom, r_left, r_right, r_drop, r_source;
    logic [30:0] r_tol;
    logic        r_conv;
    logic [19:0] r_sweeps;

    logic [31:0] mem [NPTS];
    logic [31:0] r_rdata;
    logic [AW-1:0] rd_addr;

    logic [CW-1:0] r_i, r_j;
    logic [2:0]    r_k, r_nrd;
    logic signed [35:0] r_acc;
    logic [31:0]   r_old;
    logic [32:0]   r_worst;
    logic [31:0]   r_val;
    logic          r_ovalid;
    logic [5:0]    r_col, r_row;
    logic          r_mode;   // 1 = hole corner average

    function automatic logic [AW-1:0] addr(input logic [CW-1:0] i, input logic [CW-1:0] j);
        return AW'(i) + AW'(j) * AW'(ROWLEN);
    endfunction

    assign cfg_ch.ready = (r_state == S_IDLE);
    assign in_ch.ready  = (r_state == S_IDLE);
    assign out_ch.valid = r_ovalid;
    assign out_ch.value = r_val;
    assign out_ch.converged = r_conv;
    assign out_ch.sweep_count = r_sweeps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bottom <= 32'd104857600;
            r_left   <= 32'd52428800;
            r_right  <= 32'd78643200;
            r_drop   <= 32'd1966080;
            r_source <= 32'd0;
            r_tol    <= 31'd1;
        end else if (cfg_ch.valid && cfg_ch.ready) begin
            unique case (cfg_ch.index)
                R_BOTTOM: r_bottom <= cfg_ch.data;
                R_LEFT:   r_left   <= cfg_ch.data;
                R_RIGHT:  r_right  <= cfg_ch.data;
                R_DROP:   r_drop   <= cfg_ch.data;
                R_SOURCE: r_source <= cfg_ch.data;
                R_TOL:    r_tol    <= cfg_ch.data[30:0];
                default: ;
            endcase
        end
    end

    // classification of the point under visit
    logic in_hole, is_hole_edge, is_corner;
    logic [CW-1:0] nb_i [4];
    logic [CW-1:0] nb_j [4];
    logic [31:0] init_v;

    always_comb begin
        in_hole = (r_i >= CW'(LO1)) && (r_i <= CW'(LO2)) &&
                  (r_j >= CW'(LO1)) && (r_j <= CW'(LO2));
        is_hole_edge = in_hole && ((r_i == CW'(LO1)) || (r_i == CW'(LO2)) ||
                       (r_j == CW'(LO1)) || (r_j == CW'(LO2)));
        is_corner = (r_i == CW'(LO1) || r_i == CW'(LO2)) &&
                    (r_j == CW'(LO1) || r_j == CW'(LO2));
        nb_i[0] = r_i + 1'b1; nb_j[0] = r_j;
        nb_i[1] = r_i - 1'b1; nb_j[1] = r_j;
        nb_i[2] = r_i;        nb_j[2] = r_j + 1'b1;
        nb_i[3] = r_i;        nb_j[3] = r_j - 1'b1;
        if (r_phase == P_TOP) begin
            nb_i[0] = r_i; nb_j[0] = r_j - 1'b1;
        end else if (r_phase == P_HOLE) begin
            if (is_corner) begin
                nb_i[0] = (r_i == CW'(LO1)) ? r_i - 1'b1 : r_i + 1'b1;
                nb_j[0] = r_j;
                nb_i[1] = r_i;
                nb_j[1] = (r_j == CW'(LO1)) ? r_j - 1'b1 : r_j + 1'b1;
            end else if (r_j == CW'(LO1)) begin
                nb_i[0] = r_i; nb_j[0] = r_j - 1'b1;
            end else if (r_j == CW'(LO2)) begin
                nb_i[0] = r_i; nb_j[0] = r_j + 1'b1;
            end else if (r_i == CW'(LO1)) begin
                nb_i[0] = r_i - 1'b1; nb_j[0] = r_j;
            end else begin
                nb_i[0] = r_i + 1'b1; nb_j[0] = r_j;
            end
        end
        if (r_j == '0) init_v = r_bottom;
        else if (r_i == '0) init_v = r_left;
        else if (r_i == CW'(NX)) init_v = r_right;
        else if (r_j == CW'(NX)) init_v = sat32(-36'($signed(r_drop)));
        else init_v = '0;
    end

    logic        we;
    logic [AW-1:0] waddr;
    logic [31:0] wdata;
    logic signed [35:0] nv36;
    logic [31:0] nv, dabs;
    logic signed [33:0] diff;

    always_comb begin
        nv36 = r_acc;
        if (r_phase == P_INNER) nv36 = (r_acc - 36'($signed(r_source))) >>> 2;
        else if (r_phase == P_TOP) nv36 = r_acc - 36'($signed(r_drop));
        else if (r_mode) nv36 = r_acc >>> 1;
        nv = sat32(nv36);
        diff = 34'($signed(nv)) - 34'($signed(r_old));
        dabs = diff[33] ? 32'(-diff) : diff[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[waddr] <= wdata;
        r_rdata <= mem[rd_addr];
    end

    // advance to next point of the current sweep phase; returns done
    logic [CW-1:0] nx_i, nx_j;
    logic nx_done;
    always_comb begin
        nx_i = r_i + 1'b1;
        nx_j = r_j;
        nx_done = 1'b0;
        if (r_phase == P_INNER) begin
            if (r_i == CW'(NX - 1)) begin
                nx_i = CW'(1);
                nx_j = r_j + 1'b1;
                nx_done = (r_j == CW'(NX - 1));
            end
        end else if (r_phase == P_TOP) begin
            nx_done = (r_i == CW'(NX - 1));
        end else begin
            if (r_i == CW'(LO2)) begin
                nx_i = CW'(LO1);
                nx_j = r_j + 1'b1;
                nx_done = (r_j == CW'(LO2));
            end
        end
    end

    always_comb begin
        we = 1'b0;
        waddr = addr(r_i, r_j);
        wdata = nv;
        if (r_state == S_INIT) begin
            we = 1'b1;
            wdata = init_v;
        end else if (r_state == S_WR) begin
            we = 1'b1;
        end
        rd_addr = addr(nb_i[r_k[1:0]], nb_j[r_k[1:0]]);
        if (r_k == 3'd4) rd_addr = addr(r_i, r_j);
        if (r_state == S_IDLE) rd_addr = addr(in_ch.column[CW-1:0], in_ch.row[CW-1:0]);
        n_state = r_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_conv   <= 1'b0;
            r_sweeps <= '0;
            r_phase  <= P_INNER;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_ch.valid) begin
                        r_col  <= in_ch.column;
                        r_row  <= in_ch.row;
                        r_i    <= '0;
                        r_j    <= '0;
                        r_worst <= '0;
                        unique case (t_kind'(in_ch.kind))
                            K_INIT:  r_state <= S_INIT;
                            K_SWEEP: begin
                                r_phase <= P_INNER;
                                r_i <= CW'(1);
                                r_j <= CW'(1);
                                r_state <= S_SCAN;
                            end
                            K_READ:  r_state <= S_READ;
                            default: begin
                                r_val <= '0;
                                r_ovalid <= 1'b1;
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_INIT: begin
                    if (r_i == CW'(NX)) begin
                        r_i <= '0;
                        if (r_j == CW'(NX)) begin
                            r_val <= '0;
                            r_conv <= 1'b0;
                            r_sweeps <= '0;
                            r_ovalid <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_j <= r_j + 1'b1;
                        end
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_READ: begin
                    // rdata registered from address presented in idle
                    r_val <= (r_col <= 6'(NX) && r_row <= 6'(NX)) ? r_rdata : '0;
                    r_ovalid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_SCAN: begin
                    if ((r_phase == P_INNER && in_hole) ||
                        (r_phase == P_HOLE && !is_hole_edge)) begin
                        r_i <= nx_i;
                        r_j <= nx_j;
                    end else begin
                        r_k <= 3'd0;
                        r_acc <= '0;
                        r_mode <= (r_phase == P_HOLE) && is_corner;
                        if (r_phase == P_INNER) r_nrd <= 3'd4;
                        else if (r_phase == P_HOLE && is_corner) r_nrd <= 3'd2;
                        else r_nrd <= 3'd1;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    // address for r_k presented this cycle
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (r_k == 3'd4) r_old <= r_rdata;
                    else r_acc <= r_acc + 36'($signed(r_rdata));
                    if (r_k + 1'b1 == r_nrd && r_phase != P_INNER) begin
                        r_state <= S_CALC;
                    end else if (r_k == 3'd4) begin
                        r_state <= S_CALC;
                    end else begin
                        r_k <= r_k + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_CALC: begin
                    r_k <= 3'd0;
                    if (r_phase == P_INNER && dabs > r_worst[31:0] && !r_worst[32])
                        r_worst <= {1'b0, dabs};
                    r_state <= S_WR;
                end
                S_WR: begin
                    r_i <= nx_i;
                    r_j <= nx_j;
                    r_state <= S_SCAN;
                    if (nx_done) begin
                        unique case (r_phase)
                            P_INNER: begin
                                r_phase <= P_TOP;
                                r_i <= CW'(1);
                                r_j <= CW'(NX);
                            end
                            P_TOP: begin
                                r_phase <= P_HOLE;
                                r_i <= CW'(LO1);
                                r_j <= CW'(LO1);
                            end
                            default: begin
                                // change beyond the signed range reports as its maximum
                                r_val <= r_worst[31] ? 32'h7FFF_FFFF : r_worst[31:0];
                                r_conv <= (r_worst[31:0] < {1'b0, r_tol});
                                if (r_sweeps != SWEEP_MAX) r_sweeps <= r_sweeps + 1'b1;
                                r_ovalid <= 1'b1;
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_OUT: begin
                    if (out_ch.ready) begin
                        r_ovalid <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= n_state;
            endcase
        end
    end

endmodule
